[rtl/core/sbt_pkg.sv]
package sbt_pkg;

    // Table geometry
    localparam int NUM_ENTRIES = 32;
    localparam int IDX_W       = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;

    // Field widths
    localparam int ADDR_W   = 32;
    localparam int WORD_W   = 32;
    localparam int LEN_W    = 4;
    localparam int STATUS_W = 3;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Register reset values
    localparam logic [WORD_W-1:0] BREAK_WORD_RST = 32'd13;
    localparam logic [LEN_W-1:0]  REQ_LEN_RST    = 4'd4;

    // Register indexes (byte address bit 2)
    localparam logic REG_BREAK_WORD = 1'b0;
    localparam logic REG_REQ_LEN    = 1'b1;

    // Request kinds
    localparam logic FUNC_SET   = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Result status codes
    typedef logic [STATUS_W-1:0] sbt_status_t;
    localparam sbt_status_t STAT_OK       = 3'd0;
    localparam sbt_status_t STAT_BAD_LEN  = 3'd1;
    localparam sbt_status_t STAT_DUP      = 3'd2;
    localparam sbt_status_t STAT_FULL     = 3'd3;
    localparam sbt_status_t STAT_NOT_SET  = 3'd4;

    // Search token handed from cell to cell
    typedef struct packed {
        logic              valid;
        logic              func;
        logic [ADDR_W-1:0] addr;
        logic              hit;
        logic              hit_left;
        logic [WORD_W-1:0] hit_word;
        logic              free_found;
        logic [IDX_W-1:0]  free_idx;
    } sbt_pkt_t;

    // Entry allocation broadcast from the controller
    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  idx;
        logic [ADDR_W-1:0] addr;
        logic [WORD_W-1:0] word;
        logic              left;
    } sbt_alloc_t;

endpackage

[rtl/core/sbt_cell.sv]
module sbt_cell
    import sbt_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [IDX_W-1:0] cell_index,
    input  sbt_pkt_t         pkt_in,
    input  sbt_alloc_t       alloc,
    output sbt_pkt_t         pkt_out
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [WORD_W-1:0] word_reg;
    logic              left_reg;
    sbt_pkt_t          pkt_reg, pkt_next;
    logic              hit_here;
    logic              alloc_here;

    assign hit_here   = pkt_in.valid && valid_reg && (addr_reg == pkt_in.addr);
    assign alloc_here = alloc.en && (alloc.idx == cell_index);

    // Token update: report a match and the first free entry seen so far
    always_comb begin
        pkt_next = pkt_in;
        if (hit_here) begin
            pkt_next.hit      = 1'b1;
            pkt_next.hit_left = left_reg;
            pkt_next.hit_word = word_reg;
        end
        if (!pkt_in.free_found && !valid_reg) begin
            pkt_next.free_found = 1'b1;
            pkt_next.free_idx   = cell_index;
        end
    end

    // Entry valid: set on allocation, dropped when a clear passes a match
    always_comb begin
        valid_next = valid_reg;
        if (alloc_here) begin
            valid_next = 1'b1;
        end else if (hit_here && pkt_in.func == FUNC_CLEAR) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pkt_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            pkt_reg   <= pkt_next;
        end
    end

    // Entry payload
    always_ff @(posedge aclk) begin
        if (alloc_here) begin
            addr_reg <= alloc.addr;
            word_reg <= alloc.word;
            left_reg <= alloc.left;
        end
    end

    assign pkt_out = pkt_reg;

endmodule

[rtl/core/sbt_cfg.sv]
module sbt_cfg
    import sbt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [WORD_W-1:0]  break_word,
    output logic [LEN_W-1:0]   required_length
);

    logic [WORD_W-1:0] break_word_reg;
    logic [LEN_W-1:0]  req_len_reg;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            break_word_reg <= BREAK_WORD_RST;
            req_len_reg    <= REQ_LEN_RST;
        end else if (wr_en) begin
            unique case (paddr[2])
                REG_BREAK_WORD: break_word_reg <= pwdata[WORD_W-1:0];
                REG_REQ_LEN:    req_len_reg    <= pwdata[LEN_W-1:0];
                default:        ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (paddr[2])
            REG_BREAK_WORD: prdata = PDATA_W'(break_word_reg);
            REG_REQ_LEN:    prdata = PDATA_W'(req_len_reg);
            default:        prdata = '0;
        endcase
    end

    assign break_word      = break_word_reg;
    assign required_length = req_len_reg;

endmodule

[rtl/core/software_breakpoint_table_unit.sv]
// Channel  | Dir | Ports               | Contents
// s_       | in  | s_tvalid/tready     | breakpoint set or clear request
// m_       | out | m_tvalid/tready     | status and memory write for each request
// apb      | in  | psel..pready        | break_word (0x0), required_length (0x4)
//
// One request at a time. A request with a good length walks a search token
// down the row of NUM_ENTRIES cells, one cell per cycle, and the result is
// registered as the token leaves the last cell; a bad length gives its result
// in the cycle after acceptance. s_tready is low from acceptance until the
// result transaction completes. Reset clears all entries at once.
module software_breakpoint_table_unit
    import sbt_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    // request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [103:0]       s_tdata,  // bp_address[31:0], access_length[35:32],
                                         // exception_pc[67:36], current_word[99:68]
    input  logic               s_tuser,  // func
    // result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [71:0]        m_tdata,  // status[2:0], mem_write[3],
                                         // write_address[35:4], write_word[67:36]
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } state_t;

    state_t            state_reg, state_next;

    logic [WORD_W-1:0] break_word;
    logic [LEN_W-1:0]  required_length;

    // Request fields
    logic              in_func;
    logic [ADDR_W-1:0] in_addr;
    logic [LEN_W-1:0]  in_len;
    logic [ADDR_W-1:0] in_epc;
    logic [WORD_W-1:0] in_cur;
    logic              in_accept;
    logic              len_ok;

    logic [ADDR_W-1:0] epc_reg;
    logic [WORD_W-1:0] cur_reg;

    // Result
    logic              m_valid_reg, m_valid_next;
    sbt_status_t       status_reg, status_next;
    logic              mem_wr_reg, mem_wr_next;
    logic [ADDR_W-1:0] waddr_reg, waddr_next;
    logic [WORD_W-1:0] wword_reg, wword_next;
    logic              res_load;

    sbt_pkt_t          launch;
    sbt_pkt_t          pkt [NUM_ENTRIES+1];
    sbt_pkt_t          tail;
    sbt_alloc_t        alloc;
    logic [NUM_ENTRIES:0] pkt_valid_vec;

    assign in_func = s_tuser;
    assign in_addr = s_tdata[31:0];
    assign in_len  = s_tdata[35:32];
    assign in_epc  = s_tdata[67:36];
    assign in_cur  = s_tdata[99:68];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign len_ok    = (in_len == required_length);

    sbt_cfg u_cfg (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .break_word      (break_word),
        .required_length (required_length)
    );

    // Token launch into the first cell
    always_comb begin
        launch       = '0;
        launch.valid = in_accept && len_ok;
        launch.func  = in_func;
        launch.addr  = in_addr;
    end

    assign pkt[0] = launch;

    // Row of cells
    for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_cell
        sbt_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cell_index (IDX_W'(i)),
            .pkt_in     (pkt[i]),
            .alloc      (alloc),
            .pkt_out    (pkt[i+1])
        );
    end

    for (genvar j = 0; j <= NUM_ENTRIES; j++) begin : g_vec
        assign pkt_valid_vec[j] = pkt[j].valid;
    end

    assign tail = pkt[NUM_ENTRIES];

    // Allocation once the token has seen every entry
    always_comb begin
        alloc      = '0;
        alloc.en   = tail.valid && (tail.func == FUNC_SET) && !tail.hit && tail.free_found;
        alloc.idx  = tail.free_idx;
        alloc.addr = tail.addr;
        alloc.word = cur_reg;
        alloc.left = (tail.addr == epc_reg);
    end

    // Result decision
    always_comb begin
        status_next = STAT_OK;
        mem_wr_next = 1'b0;
        waddr_next  = '0;
        wword_next  = '0;
        res_load    = 1'b0;
        if (in_accept && !len_ok) begin
            res_load    = 1'b1;
            status_next = STAT_BAD_LEN;
        end else if (tail.valid) begin
            res_load = 1'b1;
            if (tail.func == FUNC_SET) begin
                if (tail.hit) begin
                    status_next = STAT_DUP;
                end else if (!tail.free_found) begin
                    status_next = STAT_FULL;
                end else if (tail.addr != epc_reg) begin
                    mem_wr_next = 1'b1;
                    waddr_next  = tail.addr;
                    wword_next  = break_word;
                end
            end else begin
                if (!tail.hit) begin
                    status_next = STAT_NOT_SET;
                end else if (!tail.hit_left) begin
                    mem_wr_next = 1'b1;
                    waddr_next  = tail.addr;
                    wword_next  = tail.hit_word;
                end
            end
        end
    end

    // Control
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    state_next = len_ok ? S_WALK : S_DONE;
                    if (!len_ok) begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            S_WALK: begin
                if (tail.valid) begin
                    state_next   = S_DONE;
                    m_valid_next = 1'b1;
                end
            end
            S_DONE: begin
                if (m_tready) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b0;
                end
            end
            default: begin
                state_next   = S_IDLE;
                m_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Request and result payload
    always_ff @(posedge aclk) begin
        if (in_accept) begin
            epc_reg <= in_epc;
            cur_reg <= in_cur;
        end
        if (res_load) begin
            status_reg <= status_next;
            mem_wr_reg <= mem_wr_next;
            waddr_reg  <= waddr_next;
            wword_reg  <= wword_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'b0, wword_reg, waddr_reg, mem_wr_reg, status_reg};

    // At most one search token in the row
    a_one_token: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(pkt_valid_vec))
        else $error("more than one search token in flight");

    // No new request while a result waits
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid)
        else $error("request port open while result pending");

    // Token only reaches the end while walking
    a_tail_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        tail.valid |-> (state_reg == S_WALK))
        else $error("search token outside walk");

    // No write means zero address and word
    a_quiet_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !mem_wr_reg) |-> (waddr_reg == '0 && wword_reg == '0))
        else $error("nonzero write fields without write");

    // Errors never write memory
    a_err_nowrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && status_reg != STAT_OK) |-> !mem_wr_reg)
        else $error("memory write on error status");

endmodule
